// ===== hdl/kt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, recognizer tables and transition functions for the keyword token lexer.
// No dependencies; imported by kt_step, kt_queue, keyword_token_lexer and the testbench files.
package kt_pkg;

  localparam int MAX_LINE_DEFAULT = 256;
  localparam int MAX_RES          = 3;
  localparam int Q_DEPTH          = 4;

  localparam logic [1:0] RT_TOKEN = 2'd0;
  localparam logic [1:0] RT_ERROR = 2'd1;
  localparam logic [1:0] RT_EOL   = 2'd2;

  localparam logic [6:0] S_START   = 7'd0;
  localparam logic [6:0] S_ID      = 7'd1;
  localparam logic [6:0] S_ZERO    = 7'd2;
  localparam logic [6:0] S_ZEROBAD = 7'd3;
  localparam logic [6:0] S_NUM     = 7'd4;
  localparam logic [6:0] S_WS      = 7'd5;
  localparam logic [6:0] S_CMT     = 7'd6;
  localparam logic [6:0] S_NOT     = 7'd7;
  localparam logic [6:0] S_BEC     = 7'd8;
  localparam logic [6:0] S_LT      = 7'd9;
  localparam logic [6:0] S_GT      = 7'd10;
  localparam logic [6:0] S_SLASH   = 7'd11;
  localparam logic [6:0] S_OP      = 7'd12;
  localparam logic [6:0] S_TRIE    = 7'd48;
  localparam logic [6:0] S_NONE    = 7'd127;

  localparam int         TRIE_N = 42;
  localparam logic [7:0] ROOT   = 8'd255;

  localparam logic [5:0] K_ID      = 6'd0;
  localparam logic [5:0] K_NUM     = 6'd1;
  localparam logic [5:0] K_LPAREN  = 6'd2;
  localparam logic [5:0] K_RPAREN  = 6'd3;
  localparam logic [5:0] K_LBRACE  = 6'd4;
  localparam logic [5:0] K_RBRACE  = 6'd5;
  localparam logic [5:0] K_BECOMES = 6'd12;
  localparam logic [5:0] K_EQ      = 6'd14;
  localparam logic [5:0] K_NE      = 6'd15;
  localparam logic [5:0] K_LT      = 6'd16;
  localparam logic [5:0] K_GT      = 6'd17;
  localparam logic [5:0] K_LE      = 6'd18;
  localparam logic [5:0] K_GE      = 6'd19;
  localparam logic [5:0] K_PLUS    = 6'd20;
  localparam logic [5:0] K_MINUS   = 6'd21;
  localparam logic [5:0] K_STAR    = 6'd22;
  localparam logic [5:0] K_SLASH   = 6'd23;
  localparam logic [5:0] K_PCT     = 6'd24;
  localparam logic [5:0] K_COMMA   = 6'd25;
  localparam logic [5:0] K_SEMI    = 6'd26;
  localparam logic [5:0] K_LBRACK  = 6'd29;
  localparam logic [5:0] K_RBRACK  = 6'd30;
  localparam logic [5:0] K_AMP     = 6'd31;
  localparam logic [5:0] K_LAST_OP = 6'd32;
  localparam logic [5:0] K_ERR     = 6'd62;
  localparam logic [5:0] K_WS      = 6'd63;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } kt_in_t;

  typedef struct packed {
    logic [1:0] result_type;
    logic [5:0] token_kind;
    logic [7:0] token_start;
    logic [8:0] token_length;
    logic       last_of_run;
  } kt_out_t;

  localparam logic [7:0] TRIE_UP [TRIE_N] = '{
    8'd255, 8'd0,  8'd1,  8'd2,  8'd3,  8'd4,
    8'd255, 8'd6,  8'd6,  8'd8,
    8'd255, 8'd10, 8'd11, 8'd12,
    8'd255, 8'd14, 8'd15, 8'd16, 8'd17,
    8'd14,  8'd19, 8'd20,
    8'd255, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27,
    8'd255, 8'd29, 8'd30,
    8'd255, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36,
    8'd255, 8'd38, 8'd39, 8'd40
  };

  localparam logic [7:0] TRIE_CH [TRIE_N] = '{
    "r", "e", "t", "u", "r", "n",
    "i", "f", "n", "t",
    "e", "l", "s", "e",
    "w", "h", "i", "l", "e",
    "a", "i", "n",
    "p", "r", "i", "n", "t", "l", "n",
    "n", "e", "w",
    "d", "e", "l", "e", "t", "e",
    "N", "U", "L", "L"
  };

  localparam logic [5:0] TRIE_KIND [TRIE_N] = '{
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd6,
    6'd0, 6'd7, 6'd0, 6'd13,
    6'd0, 6'd0, 6'd0, 6'd8,
    6'd0, 6'd0, 6'd0, 6'd0, 6'd9,
    6'd0, 6'd0, 6'd11,
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd10,
    6'd0, 6'd0, 6'd27,
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd28,
    6'd0, 6'd0, 6'd0, 6'd32
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_letter(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || (c == " ");
  endfunction

  function automatic logic in_trie(input logic [6:0] s);
    return (s >= S_TRIE) && (32'(s) < 32'(S_TRIE) + TRIE_N);
  endfunction

  function automatic logic [6:0] trie_child(input logic [7:0] parent, input logic [7:0] c);
    logic [6:0] r;
    r = S_NONE;
    for (int i = 0; i < TRIE_N; i++) begin
      if ((TRIE_UP[i] == parent) && (TRIE_CH[i] == c)) begin
        r = 7'(32'(S_TRIE) + i);
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] op_of(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      "(": r = S_OP + 7'(K_LPAREN);
      ")": r = S_OP + 7'(K_RPAREN);
      "{": r = S_OP + 7'(K_LBRACE);
      "}": r = S_OP + 7'(K_RBRACE);
      "+": r = S_OP + 7'(K_PLUS);
      "-": r = S_OP + 7'(K_MINUS);
      "*": r = S_OP + 7'(K_STAR);
      "%": r = S_OP + 7'(K_PCT);
      ",": r = S_OP + 7'(K_COMMA);
      ";": r = S_OP + 7'(K_SEMI);
      "[": r = S_OP + 7'(K_LBRACK);
      "]": r = S_OP + 7'(K_RBRACK);
      "&": r = S_OP + 7'(K_AMP);
      "=": r = S_BEC;
      "!": r = S_NOT;
      "<": r = S_LT;
      ">": r = S_GT;
      "/": r = S_SLASH;
      default: r = S_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] next_state(input logic [6:0] s, input logic [7:0] c);
    logic [6:0] t;
    logic [6:0] r;
    t = S_NONE;
    r = S_NONE;
    if (c[7]) begin
      r = S_NONE;
    end else if (in_trie(s)) begin
      t = trie_child(8'(s - S_TRIE), c);
      r = (t != S_NONE) ? t : (is_alnum(c) ? S_ID : S_NONE);
    end else begin
      case (s)
        S_START: begin
          if (is_space(c)) begin
            r = S_WS;
          end else if (is_letter(c)) begin
            t = trie_child(ROOT, c);
            r = (t != S_NONE) ? t : S_ID;
          end else if (c == "0") begin
            r = S_ZERO;
          end else if (is_digit(c)) begin
            r = S_NUM;
          end else begin
            r = op_of(c);
          end
        end
        S_ID:    r = is_alnum(c) ? S_ID : S_NONE;
        S_ZERO:  r = is_alnum(c) ? S_ZEROBAD : S_NONE;
        S_NUM:   r = is_digit(c) ? S_NUM : S_NONE;
        S_WS:    r = is_space(c) ? S_WS : S_NONE;
        S_CMT:   r = S_CMT;
        S_NOT:   r = (c == "=") ? S_OP + 7'(K_NE) : S_NONE;
        S_BEC:   r = (c == "=") ? S_OP + 7'(K_EQ) : S_NONE;
        S_LT:    r = (c == "=") ? S_OP + 7'(K_LE) : S_NONE;
        S_GT:    r = (c == "=") ? S_OP + 7'(K_GE) : S_NONE;
        S_SLASH: r = (c == "/") ? S_CMT : S_NONE;
        default: r = S_NONE;
      endcase
    end
    return r;
  endfunction

  function automatic logic [5:0] kind_of(input logic [6:0] s);
    logic [5:0] r;
    if (in_trie(s)) begin
      r = TRIE_KIND[6'(s - S_TRIE)];
    end else if ((s >= S_OP + 7'(K_LPAREN)) && (s <= S_OP + 7'(K_LAST_OP))) begin
      r = 6'(s - S_OP);
    end else begin
      case (s)
        S_ID:    r = K_ID;
        S_ZERO:  r = K_NUM;
        S_NUM:   r = K_NUM;
        S_WS:    r = K_WS;
        S_CMT:   r = K_WS;
        S_BEC:   r = K_BECOMES;
        S_LT:    r = K_LT;
        S_GT:    r = K_GT;
        S_SLASH: r = K_SLASH;
        default: r = K_ERR;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hdl/kt_step.sv =====
`timescale 1ns / 1ps
// Per-character step: recognizer transition, token/error/end-of-line results, next line state.
// Depends on kt_pkg.
module kt_step #(
  parameter int MAX_LINE = kt_pkg::MAX_LINE_DEFAULT
) (
  input  logic [6:0]                       dfa_state,
  input  logic [$clog2(MAX_LINE)-1:0]      start_column,
  input  logic [$clog2(MAX_LINE + 1)-1:0]  column,
  input  logic                             skipping,
  input  kt_pkg::kt_in_t                   in_data,
  output logic [6:0]                       dfa_state_next,
  output logic [$clog2(MAX_LINE)-1:0]      start_column_next,
  output logic [$clog2(MAX_LINE + 1)-1:0]  column_next,
  output logic                             skipping_next,
  output logic [1:0]                       res_n,
  output kt_pkg::kt_out_t                  res_data [kt_pkg::MAX_RES]
);
  import kt_pkg::*;

  localparam int CW = $clog2(MAX_LINE + 1);
  localparam int SW = $clog2(MAX_LINE);

  logic [6:0]    dfa;
  logic [6:0]    nx;
  logic [SW-1:0] sc;
  logic [CW-1:0] col;
  logic          skip;
  logic [5:0]    k;
  logic [1:0]    n;
  kt_out_t       res [MAX_RES];

  function automatic kt_out_t mk(input logic [1:0] rt, input logic [5:0] kind,
                                 input logic [31:0] st, input logic [31:0] len);
    kt_out_t r;
    r.result_type  = rt;
    r.token_kind   = kind;
    r.token_start  = (st > 32'd255) ? 8'hFF : 8'(st);
    r.token_length = (len > 32'd511) ? 9'h1FF : 9'(len);
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  always_comb begin
    dfa  = dfa_state;
    sc   = start_column;
    col  = column;
    skip = skipping;
    nx   = S_NONE;
    k    = K_ERR;
    n    = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    if (!skip) begin
      if (32'(col) >= 32'(MAX_LINE)) begin
        res[n] = mk(RT_ERROR, K_ID, 32'(col), 32'd0);
        n      = n + 2'd1;
        skip   = 1'b1;
      end else begin
        nx = next_state(dfa, in_data.char_code);
        if (nx == S_NONE) begin
          k = kind_of(dfa);
          if (k == K_ERR) begin
            res[n] = mk(RT_ERROR, K_ID, 32'(col), 32'd0);
            n      = n + 2'd1;
            skip   = 1'b1;
          end else begin
            if (k != K_WS) begin
              res[n] = mk(RT_TOKEN, k, 32'(sc), 32'(col) - 32'(sc));
              n      = n + 2'd1;
            end
            sc = SW'(col);
            nx = next_state(S_START, in_data.char_code);
            if (nx == S_NONE) begin
              res[n] = mk(RT_ERROR, K_ID, 32'(col), 32'd0);
              n      = n + 2'd1;
              skip   = 1'b1;
            end
          end
        end
        if (!skip) begin
          dfa = nx;
          col = col + CW'(1);
        end
      end
    end

    if (in_data.line_end) begin
      if (!skip) begin
        k = kind_of(dfa);
        if (k == K_ERR) begin
          res[n] = mk(RT_ERROR, K_ID, 32'(col), 32'd0);
          n      = n + 2'd1;
        end else if (k != K_WS) begin
          res[n] = mk(RT_TOKEN, k, 32'(sc), 32'(col) - 32'(sc));
          n      = n + 2'd1;
        end
      end
      res[n] = mk(RT_EOL, K_ID, 32'd0, 32'd0);
      n      = n + 2'd1;
      dfa    = S_START;
      sc     = '0;
      col    = '0;
      skip   = 1'b0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last_of_run = 1'b1;
    end

    dfa_state_next    = dfa;
    start_column_next = sc;
    column_next       = col;
    skipping_next     = skip;
    res_n             = n;
    res_data          = res;
  end

endmodule

// ===== hdl/kt_queue.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to three result words per cycle in order, delivers one per cycle while out_ready is high.
// Depends on kt_pkg.
module kt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_n,
  input  kt_pkg::kt_out_t push_data [kt_pkg::MAX_RES],
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output kt_pkg::kt_out_t out_data
);
  import kt_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int NW = $clog2(Q_DEPTH + 1);

  kt_out_t       mem [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign room      = (32'(count) <= Q_DEPTH - MAX_RES);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_n) begin
        mem[PW'(32'(wr_ptr) + i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PW'(32'(wr_ptr) + 32'(push_n));
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= NW'(32'(count) + 32'(push_n) - (pop ? 32'd1 : 32'd0));
    end
  end

  assert property (@(posedge clk) disable iff (rst) 32'(count) <= Q_DEPTH)
    else $error("result queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> (32'(count) + 32'(push_n) <= Q_DEPTH))
    else $error("result queue overrun");

  assert property (@(posedge clk) disable iff (rst)
    (pop && (push_n == 2'd0)) |=> (count == $past(count) - NW'(1)))
    else $error("result queue count not decremented on pop");

endmodule

// ===== hdl/keyword_token_lexer.sv =====
`timescale 1ns / 1ps
// Top level of the keyword token lexer: line state registers, step logic and result queue.
// Depends on kt_pkg, kt_step and kt_queue.
//
// One character word enters per cycle while in_ready is high and is fully processed in the cycle
// it is accepted; each character gives zero to three result words (token, error, end of line),
// which leave through a four-entry queue at one per cycle while out_ready is high. Input is taken
// whenever at most one result is waiting, so the block sustains one character per cycle as long
// as characters give at most one result each and out_ready stays high; a character with two or
// three results holds off input until at most one waits again. After an error the rest of the line is
// consumed silently until the character flagged as line end, which always yields the end-of-line word.
// Lines longer than MAX_LINE characters give an error at column MAX_LINE. No clearing pass after reset.
module keyword_token_lexer #(
  parameter int MAX_LINE = kt_pkg::MAX_LINE_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  kt_pkg::kt_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output kt_pkg::kt_out_t out_data
);
  import kt_pkg::*;

  localparam int CW = $clog2(MAX_LINE + 1);
  localparam int SW = $clog2(MAX_LINE);

  logic [6:0]    dfa_state;
  logic [6:0]    dfa_state_next;
  logic [SW-1:0] start_column;
  logic [SW-1:0] start_column_next;
  logic [CW-1:0] column;
  logic [CW-1:0] column_next;
  logic          skipping;
  logic          skipping_next;
  logic [1:0]    res_n;
  kt_out_t       res_data [MAX_RES];
  logic          accept;
  logic          room;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  kt_step #(
    .MAX_LINE(MAX_LINE)
  ) u_step (
    .dfa_state        (dfa_state),
    .start_column     (start_column),
    .column           (column),
    .skipping         (skipping),
    .in_data          (in_data),
    .dfa_state_next   (dfa_state_next),
    .start_column_next(start_column_next),
    .column_next      (column_next),
    .skipping_next    (skipping_next),
    .res_n            (res_n),
    .res_data         (res_data)
  );

  kt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_n   (accept ? res_n : 2'd0),
    .push_data(res_data),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state    <= S_START;
      start_column <= '0;
      column       <= '0;
      skipping     <= 1'b0;
    end else if (accept) begin
      dfa_state    <= dfa_state_next;
      start_column <= start_column_next;
      column       <= column_next;
      skipping     <= skipping_next;
    end
  end

endmodule

// ===== tb/keyword_token_lexer_chk.sv =====
`timescale 1ns / 1ps
// Checker for the keyword token lexer: watches both channels, predicts the result words of
// every accepted character word and compares them in order. Depends on kt_pkg.
module keyword_token_lexer_chk #(
  parameter int MAX_LINE = kt_pkg::MAX_LINE_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  kt_pkg::kt_in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  kt_pkg::kt_out_t out_data,
  output int              errors,
  output int              outstanding
);
  import kt_pkg::*;

  localparam logic [5:0] KW_RETURN  = 6'd6;
  localparam logic [5:0] KW_IF      = 6'd7;
  localparam logic [5:0] KW_ELSE    = 6'd8;
  localparam logic [5:0] KW_WHILE   = 6'd9;
  localparam logic [5:0] KW_PRINTLN = 6'd10;
  localparam logic [5:0] KW_WAIN    = 6'd11;
  localparam logic [5:0] KW_INT     = 6'd13;
  localparam logic [5:0] KW_NEW     = 6'd27;
  localparam logic [5:0] KW_DELETE  = 6'd28;
  localparam logic [5:0] KW_NULL    = 6'd32;

  localparam int         KW_COUNT = 10;
  localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
    "return", "if", "else", "while", "println", "wain", "int", "new", "delete", "NULL"
  };
  localparam int          KW_LEN  [KW_COUNT] = '{6, 2, 4, 5, 7, 4, 3, 3, 6, 4};
  localparam logic [5:0]  KW_KIND [KW_COUNT] = '{
    KW_RETURN, KW_IF, KW_ELSE, KW_WHILE, KW_PRINTLN, KW_WAIN, KW_INT, KW_NEW, KW_DELETE,
    KW_NULL
  };

  typedef enum logic [3:0] {
    LX_START, LX_ID, LX_ZERO, LX_ZEROBAD, LX_NUM, LX_WS, LX_CMT, LX_NOT, LX_BEC, LX_LT,
    LX_GT, LX_SLASH, LX_OP, LX_KW, LX_NONE
  } lex_class_e;

  typedef struct packed {
    lex_class_e       cls;
    logic [5:0]       op;
    logic [3:0]       plen;
    logic [7:0][7:0]  pfx;
  } lex_pos_t;

  lex_pos_t   lx;
  int         tok_col;
  int         column;
  logic       skip;
  kt_out_t    expected_words[$];
  kt_out_t    pending_word;
  logic       have_pending;
  kt_out_t    want;

  function automatic logic char_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic char_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic char_space(input logic [7:0] c);
    return c == 8'h09 || c == 8'h0A || c == 8'h0D || c == " ";
  endfunction

  function automatic logic [7:0] kw_char(input int k, input int j);
    return KW_TEXT[k][8*(KW_LEN[k]-1-j) +: 8];
  endfunction

  function automatic logic kw_extends(input lex_pos_t p, input logic [7:0] c);
    logic hit;
    logic ok;
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (KW_LEN[k] > int'(p.plen)) begin
        ok = 1'b1;
        for (int j = 0; j < int'(p.plen); j++) begin
          if (kw_char(k, j) != p.pfx[j]) ok = 1'b0;
        end
        if (ok && kw_char(k, int'(p.plen)) == c) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [5:0] lex_kind(input lex_pos_t p);
    logic [5:0] k;
    logic       ok;
    k = K_ERR;
    case (p.cls)
      LX_ID:           k = K_ID;
      LX_ZERO, LX_NUM: k = K_NUM;
      LX_WS, LX_CMT:   k = K_WS;
      LX_BEC:          k = K_BECOMES;
      LX_LT:           k = K_LT;
      LX_GT:           k = K_GT;
      LX_SLASH:        k = K_SLASH;
      LX_OP:           k = p.op;
      LX_KW: begin
        k = K_ID;
        for (int i = 0; i < KW_COUNT; i++) begin
          if (KW_LEN[i] == int'(p.plen)) begin
            ok = 1'b1;
            for (int j = 0; j < KW_LEN[i]; j++) begin
              if (kw_char(i, j) != p.pfx[j]) ok = 1'b0;
            end
            if (ok) k = KW_KIND[i];
          end
        end
      end
      default:         k = K_ERR;
    endcase
    return k;
  endfunction

  function automatic lex_pos_t lex_next(input lex_pos_t p, input logic [7:0] c);
    lex_pos_t q;
    q = '0;
    q.cls = LX_NONE;
    if (c[7]) return q;
    case (p.cls)
      LX_START: begin
        if (char_space(c)) begin
          q.cls = LX_WS;
        end else if (char_letter(c)) begin
          if (kw_extends(p, c)) begin
            q.cls    = LX_KW;
            q.pfx[0] = c;
            q.plen   = 4'd1;
          end else begin
            q.cls = LX_ID;
          end
        end else if (c == "0") begin
          q.cls = LX_ZERO;
        end else if (char_digit(c)) begin
          q.cls = LX_NUM;
        end else begin
          q.cls = LX_OP;
          case (c)
            "(": q.op = K_LPAREN;
            ")": q.op = K_RPAREN;
            "{": q.op = K_LBRACE;
            "}": q.op = K_RBRACE;
            "+": q.op = K_PLUS;
            "-": q.op = K_MINUS;
            "*": q.op = K_STAR;
            "%": q.op = K_PCT;
            ",": q.op = K_COMMA;
            ";": q.op = K_SEMI;
            "[": q.op = K_LBRACK;
            "]": q.op = K_RBRACK;
            "&": q.op = K_AMP;
            "=": q.cls = LX_BEC;
            "!": q.cls = LX_NOT;
            "<": q.cls = LX_LT;
            ">": q.cls = LX_GT;
            "/": q.cls = LX_SLASH;
            default: q.cls = LX_NONE;
          endcase
        end
      end
      LX_KW: begin
        if (kw_extends(p, c)) begin
          q = p;
          q.pfx[p.plen] = c;
          q.plen = p.plen + 4'd1;
        end else if (char_digit(c) || char_letter(c)) begin
          q.cls = LX_ID;
        end
      end
      LX_ID:    if (char_digit(c) || char_letter(c)) q.cls = LX_ID;
      LX_ZERO:  if (char_digit(c) || char_letter(c)) q.cls = LX_ZEROBAD;
      LX_NUM:   if (char_digit(c)) q.cls = LX_NUM;
      LX_WS:    if (char_space(c)) q.cls = LX_WS;
      LX_CMT:   q.cls = LX_CMT;
      LX_SLASH: if (c == "/") q.cls = LX_CMT;
      LX_NOT: begin
        if (c == "=") begin
          q.cls = LX_OP;
          q.op  = K_NE;
        end
      end
      LX_BEC: begin
        if (c == "=") begin
          q.cls = LX_OP;
          q.op  = K_EQ;
        end
      end
      LX_LT: begin
        if (c == "=") begin
          q.cls = LX_OP;
          q.op  = K_LE;
        end
      end
      LX_GT: begin
        if (c == "=") begin
          q.cls = LX_OP;
          q.op  = K_GE;
        end
      end
      default: q.cls = LX_NONE;
    endcase
    return q;
  endfunction

  task automatic note_result(input logic [1:0] rt, input logic [5:0] kind, input int start,
                             input int len);
    if (have_pending) expected_words.insert(expected_words.size(), pending_word);
    pending_word.result_type  = rt;
    pending_word.token_kind   = kind;
    pending_word.token_start  = (start > 255) ? 8'd255 : 8'(start);
    pending_word.token_length = (len > 511) ? 9'd511 : 9'(len);
    pending_word.last_of_run  = 1'b0;
    have_pending = 1'b1;
  endtask

  task automatic line_clear();
    lx      = '0;
    tok_col = 0;
    column  = 0;
    skip    = 1'b0;
  endtask

  task automatic lex_char(input logic [7:0] c, input logic last);
    lex_pos_t   nx;
    logic [5:0] k;
    int         col;
    have_pending = 1'b0;
    if (!skip) begin
      col = column;
      if (col >= MAX_LINE) begin
        note_result(RT_ERROR, K_ID, col, 0);
        skip = 1'b1;
      end else begin
        nx = lex_next(lx, c);
        if (nx.cls == LX_NONE) begin
          k = lex_kind(lx);
          if (k == K_ERR) begin
            note_result(RT_ERROR, K_ID, col, 0);
            skip = 1'b1;
          end else begin
            if (k != K_WS) note_result(RT_TOKEN, k, tok_col, col - tok_col);
            tok_col = col;
            nx = lex_next('0, c);
            if (nx.cls == LX_NONE) begin
              note_result(RT_ERROR, K_ID, col, 0);
              skip = 1'b1;
            end
          end
        end
        if (!skip) begin
          lx     = nx;
          column = col + 1;
        end
      end
    end
    if (last) begin
      if (!skip) begin
        k = lex_kind(lx);
        if (k == K_ERR) note_result(RT_ERROR, K_ID, column, 0);
        else if (k != K_WS) note_result(RT_TOKEN, k, tok_col, column - tok_col);
      end
      note_result(RT_EOL, K_ID, 0, 0);
      line_clear();
    end
    if (have_pending) begin
      pending_word.last_of_run = 1'b1;
      expected_words.insert(expected_words.size(), pending_word);
      have_pending = 1'b0;
    end
  endtask

  task automatic report(input string what, input kt_out_t exp_w, input kt_out_t act_w);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: expected type %0d kind %0d start %0d len %0d last %0b,",
               $time, what, exp_w.result_type, exp_w.token_kind, exp_w.token_start,
               exp_w.token_length, exp_w.last_of_run,
               " got type %0d kind %0d start %0d len %0d last %0b",
               act_w.result_type, act_w.token_kind, act_w.token_start,
               act_w.token_length, act_w.last_of_run);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_clear();
      expected_words.delete();
      have_pending = 1'b0;
    end else begin
      if (in_valid && in_ready) lex_char(in_data.char_code, in_data.line_end);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report("result word with none expected", '0, out_data);
        end else begin
          want = expected_words.pop_front();
          if (want.result_type !== out_data.result_type ||
              want.token_kind !== out_data.token_kind ||
              want.token_start !== out_data.token_start ||
              want.token_length !== out_data.token_length ||
              want.last_of_run !== out_data.last_of_run) begin
            report("result word mismatch", want, out_data);
          end
        end
      end
    end
    outstanding = expected_words.size();
  end

endmodule

// ===== tb/keyword_token_lexer_tb.sv =====
`timescale 1ns / 1ps
// Top of the keyword token lexer testbench: clock, reset, line stimulus and the verdict.
// Depends on kt_pkg, keyword_token_lexer and keyword_token_lexer_chk.
module keyword_token_lexer_tb;
  import kt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 300;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_ready;
  kt_in_t  in_data;
  logic    out_valid;
  logic    out_ready = 1'b0;
  kt_out_t out_data;
  int      errors;
  int      outstanding;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      sent;
  logic [7:0] line_buf[$];

  string kw_words [10] = '{
    "return", "if", "else", "while", "println", "wain", "int", "new", "delete", "NULL"
  };
  string cmp_ops [8] = '{"=", "==", "!=", "<", "<=", ">", ">=", "/"};
  string single_ops = "(){}+-*%,;[]&";

  keyword_token_lexer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  keyword_token_lexer_chk token_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("keyword_token_lexer_tb: errors");
      $finish;
    end
  end

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(3) == 0) ? 8'("0" + $urandom_range(9)) : rand_letter();
  endfunction

  task automatic put_char(input logic [7:0] c, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_code: c, line_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) put_char(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic add_char(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic say_line(input string s);
    push_text(s);
    send_line();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic add_piece(input int sel);
    int    k;
    int    n;
    string w;
    case (sel)
      0: begin
        push_text(kw_words[$urandom_range(9)]);
        if ($urandom_range(3) == 0) add_char(rand_alnum());
      end
      1: begin
        w = kw_words[$urandom_range(9)];
        n = $urandom_range(1, w.len() - 1);
        for (int i = 0; i < n; i++) add_char(w[i]);
      end
      2: begin
        add_char(rand_letter());
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) add_char(rand_alnum());
      end
      3: begin
        if ($urandom_range(2) == 0) begin
          add_char("0");
        end else begin
          add_char(8'("1" + $urandom_range(8)));
          n = $urandom_range(3);
          for (int i = 0; i < n; i++) add_char(8'("0" + $urandom_range(9)));
        end
      end
      4: begin
        k = $urandom_range(single_ops.len() - 1);
        add_char(single_ops[k]);
      end
      5: push_text(cmp_ops[$urandom_range(7)]);
      6, 7: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(3))
            0: add_char(8'h09);
            1: add_char(8'h0A);
            2: add_char(8'h0D);
            default: add_char(" ");
          endcase
        end
      end
      8: begin
        push_text("//");
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) add_char(8'($urandom_range(32, 126)));
      end
      default: add_char(" ");
    endcase
  endtask

  task automatic build_line();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) add_piece($urandom_range(0, 10));
    sent += line_buf.size();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: add_char(8'($urandom_range(255)));
        1: add_char("!");
        2: begin
          add_char("0");
          add_char(rand_alnum());
        end
        default: add_char(8'($urandom_range(128, 255)));
      endcase
      if ($urandom_range(1)) add_piece($urandom_range(0, 10));
    end
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    say_line("if(0)");
    say_line("a!b;");
    push_text("//");
    add_char(8'h80);
    say_line("z");
    add_char(8'h00);
    send_line();
    say_line("0x");
    add_char(8'hFF);
    send_line();
    say_line("<=");
    say_line("NULL");

    // hold off until the directed words have all come back
    drain();

    add_char("q");
    for (int i = 1; i < 256; i++) add_char(rand_alnum());
    send_line();
    for (int i = 0; i < 260; i++) add_char((i % 4 == 3) ? 8'(" ") : 8'("b"));
    send_line();

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      while (sent < (phase + 1) * RANDOM_CHARS / 4) begin
        build_line();
        send_line();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("keyword_token_lexer_tb: clean");
    end else begin
      $display("keyword_token_lexer_tb: errors");
    end
    $finish;
  end

endmodule

// ===== keyword_token_lexer.f =====
hdl/kt_pkg.sv
hdl/kt_step.sv
hdl/kt_queue.sv
hdl/keyword_token_lexer.sv
tb/keyword_token_lexer_chk.sv
tb/keyword_token_lexer_tb.sv
